### sv/triangle_row_span_top_assert.svh
// ----------------------------------------------------------------------------
// Triangle row span assertion macros
// Concurrent check wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_ROW_SPAN_TOP_ASSERT_SVH
`define TRIANGLE_ROW_SPAN_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TRS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("triangle_row_span check failed");
`define TRS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle_row_span check failed");
`else
`define TRS_ASSERT(lbl, expr)
`define TRS_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

### sv/trs_pkg.sv
// ----------------------------------------------------------------------------
// Triangle row span package
// Word types and pipeline constants shared by the lanes, merge and top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

  localparam int COORD_BITS = 12;
  localparam int NUM_LANES  = 3;
  // setup, multiply, one stage per quotient bit, floor fix
  localparam int LANE_LAT   = COORD_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t vertex0_x;
    coord_t vertex0_y;
    coord_t vertex1_x;
    coord_t vertex1_y;
    coord_t vertex2_x;
    coord_t vertex2_y;
    coord_t row_y;
  } in_word_t;

  typedef struct packed {
    coord_t span_left;
    coord_t span_right;
    logic   span_valid;
  } out_word_t;

  typedef struct packed {
    logic   hit;
    coord_t x;
  } lane_res_t;

endpackage

`default_nettype wire

### sv/trs_lane.sv
// ----------------------------------------------------------------------------
// Triangle row span edge lane
// Crossing of one edge with the row: setup, multiply, restoring divide one
// quotient bit per stage, then floor correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_lane (
  input  wire                clk,
  input  trs_pkg::coord_t    ax,
  input  trs_pkg::coord_t    ay,
  input  trs_pkg::coord_t    bx,
  input  trs_pkg::coord_t    by,
  input  trs_pkg::coord_t    row,
  output trs_pkg::lane_res_t res
);
  import trs_pkg::*;

  localparam int C = COORD_BITS;

  // setup
  logic signed [C:0]   lx_w, ly_w, hx_w, hy_w, r_w, dy_w, den_w, dx_w;
  logic                hit_w;
  coord_t              s1_lx;
  logic [C-1:0]        s1_dy, s1_den;
  logic signed [C:0]   s1_dx;
  logic                s1_hit;

  always_comb begin
    if (ay < by) begin
      lx_w = {ax[C-1], ax}; ly_w = {ay[C-1], ay}; hx_w = {bx[C-1], bx}; hy_w = {by[C-1], by};
    end else begin
      lx_w = {bx[C-1], bx}; ly_w = {by[C-1], by}; hx_w = {ax[C-1], ax}; hy_w = {ay[C-1], ay};
    end
    r_w   = {row[C-1], row};
    dy_w  = r_w - ly_w;
    den_w = hy_w - ly_w;
    dx_w  = hx_w - lx_w;
    hit_w = (ay != by) && (r_w >= ly_w) && (r_w <= hy_w);
  end

  always_ff @(posedge clk) begin
    s1_lx  <= lx_w[C-1:0];
    s1_dy  <= dy_w[C-1:0];
    s1_den <= den_w[C-1:0];
    s1_dx  <= dx_w;
    s1_hit <= hit_w;
  end

  // multiply
  logic [C-1:0] mag_w;
  assign mag_w = s1_dx[C] ? C'(-s1_dx) : s1_dx[C-1:0];

  logic [C-1:0] rem  [0:C];
  logic [C-1:0] nlo  [0:C];
  logic [C-1:0] quo  [0:C];
  logic [C-1:0] den  [0:C];
  coord_t       lx   [0:C];
  logic         neg  [0:C];
  logic         hit  [0:C];

  logic [2*C-1:0] prod_w;
  assign prod_w = s1_dy * mag_w;

  always_ff @(posedge clk) begin
    rem[0] <= prod_w[2*C-1:C];
    nlo[0] <= prod_w[C-1:0];
    quo[0] <= '0;
    den[0] <= s1_den;
    lx[0]  <= s1_lx;
    neg[0] <= s1_dx[C];
    hit[0] <= s1_hit;
  end

  // divide
  for (genvar k = 0; k < C; k++) begin : g_div
    logic [C:0] t_w, d_w;
    logic       ge_w;
    assign t_w  = {rem[k], nlo[k][C-1]};
    assign d_w  = t_w - {1'b0, den[k]};
    assign ge_w = t_w >= {1'b0, den[k]};
    always_ff @(posedge clk) begin
      rem[k+1] <= ge_w ? d_w[C-1:0] : t_w[C-1:0];
      nlo[k+1] <= {nlo[k][C-2:0], 1'b0};
      quo[k+1] <= {quo[k][C-2:0], ge_w};
      den[k+1] <= den[k];
      lx[k+1]  <= lx[k];
      neg[k+1] <= neg[k];
      hit[k+1] <= hit[k];
    end
  end

  // floor fix
  logic [C:0] qf_w, x_w;
  always_comb begin
    if (neg[C]) begin
      qf_w = {1'b0, quo[C]} + {{C{1'b0}}, (rem[C] != '0)};
      x_w  = {lx[C][C-1], lx[C]} - qf_w;
    end else begin
      qf_w = {1'b0, quo[C]};
      x_w  = {lx[C][C-1], lx[C]} + qf_w;
    end
  end

  always_ff @(posedge clk) begin
    res.hit <= hit[C];
    res.x   <= x_w[C-1:0];
  end

endmodule

`default_nettype wire

### sv/trs_merge.sv
// ----------------------------------------------------------------------------
// Triangle row span merge
// Combine the lane crossings into the least and greatest x, register the word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trs_merge (
  input  wire                clk,
  input  wire                rst,
  input  wire                vld,
  input  wire                in_rng,
  input  trs_pkg::lane_res_t lane [trs_pkg::NUM_LANES],
  output logic               done,
  output trs_pkg::out_word_t result
);
  import trs_pkg::*;

  coord_t    left_w, right_w;
  logic      any_w;
  out_word_t word_w;

  always_comb begin
    left_w  = '0;
    right_w = '0;
    any_w   = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lane[i].hit) begin
        if (!any_w || lane[i].x < left_w) left_w = lane[i].x;
        if (!any_w || lane[i].x > right_w) right_w = lane[i].x;
        any_w = 1'b1;
      end
    end
    if (in_rng && any_w) begin
      word_w.span_left  = left_w;
      word_w.span_right = right_w;
      word_w.span_valid = 1'b1;
    end else begin
      word_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld;
    end
    result <= word_w;
  end

endmodule

`default_nettype wire

### sv/triangle_row_span_top.sv
// ----------------------------------------------------------------------------
// Triangle row span top
// Horizontal span that a triangle covers on one scanline row.
// ----------------------------------------------------------------------------
// One word is taken every cycle: busy stays low, and start with a word at any
// edge enters the pipeline. Three edge lanes run in parallel, each with a
// pipelined restoring divider of one quotient bit per stage, so a result
// appears with done exactly COORD_BITS + 4 cycles after its word was taken
// and must be captured in that cycle; results leave in input order.
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_row_span_top_assert.svh"

module triangle_row_span_top (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  trs_pkg::in_word_t  item,
  output logic               done,
  output trs_pkg::out_word_t result
);
  import trs_pkg::*;

  coord_t    lo_w, hi_w;
  logic      rng_w;
  lane_res_t lane [NUM_LANES];
  logic      vld  [0:LANE_LAT-1];
  logic      rng  [0:LANE_LAT-1];

  assign busy = 1'b0;

  always_comb begin
    lo_w = item.vertex0_y;
    hi_w = item.vertex0_y;
    if (item.vertex1_y < lo_w) lo_w = item.vertex1_y;
    if (item.vertex1_y > hi_w) hi_w = item.vertex1_y;
    if (item.vertex2_y < lo_w) lo_w = item.vertex2_y;
    if (item.vertex2_y > hi_w) hi_w = item.vertex2_y;
    rng_w = (item.row_y >= lo_w) && (item.row_y < hi_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int i = 1; i < LANE_LAT; i++) vld[i] <= vld[i-1];
    end
    rng[0] <= rng_w;
    for (int i = 1; i < LANE_LAT; i++) rng[i] <= rng[i-1];
  end

  trs_lane u_lane0 (
    .clk(clk), .ax(item.vertex0_x), .ay(item.vertex0_y),
    .bx(item.vertex1_x), .by(item.vertex1_y), .row(item.row_y), .res(lane[0])
  );
  trs_lane u_lane1 (
    .clk(clk), .ax(item.vertex1_x), .ay(item.vertex1_y),
    .bx(item.vertex2_x), .by(item.vertex2_y), .row(item.row_y), .res(lane[1])
  );
  trs_lane u_lane2 (
    .clk(clk), .ax(item.vertex2_x), .ay(item.vertex2_y),
    .bx(item.vertex0_x), .by(item.vertex0_y), .row(item.row_y), .res(lane[2])
  );

  trs_merge u_merge (
    .clk(clk), .rst(rst), .vld(vld[LANE_LAT-1]), .in_rng(rng[LANE_LAT-1]),
    .lane(lane), .done(done), .result(result)
  );

  `TRS_ASSERT(a_never_busy, !busy)
  `TRS_ASSERT_IMPLY(a_span_order, done && result.span_valid,
                    result.span_left <= result.span_right)
  `TRS_ASSERT_IMPLY(a_empty_zero, done && !result.span_valid,
                    result.span_left == '0 && result.span_right == '0)

endmodule

`default_nettype wire
